// File: src/bee_pkg.sv
package bee_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned COUNT_W     = 16;

  localparam logic [7:0] CH_TRUE    = 8'h56;
  localparam logic [7:0] CH_FALSE   = 8'h46;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_NOT     = 8'h21;
  localparam logic [7:0] CH_AND     = 8'h26;
  localparam logic [7:0] CH_OR      = 8'h7c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // binary operator codes equal their precedence
  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_OR   = 2'd1,
    OP_AND  = 2'd2,
    OP_NOT  = 2'd3
  } op_code_e;

  typedef enum logic [1:0] {
    VAL_NONE,
    VAL_PUSH,
    VAL_COMBINE,
    VAL_FLIP
  } val_cmd_e;

  typedef enum logic [1:0] {
    OPS_NONE,
    OPS_PUSH,
    OPS_POP
  } ops_cmd_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } bee_in_t;

  typedef struct packed {
    logic               truth_value;
    logic [COUNT_W-1:0] expr_number;
    logic               status;
  } bee_out_t;

  typedef struct packed {
    val_cmd_e val_cmd;
    ops_cmd_e ops_cmd;
    op_code_e push_code;
    logic     set_malformed;
    logic     set_line_open;
    logic     clear_line;
    logic     load_pend;
    logic     pend_value;
    logic     flip_pend;
    logic     emit;
  } bee_cmd_t;

  typedef struct packed {
    logic     vd_zero;
    logic     vd_lt2;
    logic     vd_full;
    logic     od_zero;
    logic     od_full;
    op_code_e op_top;
    logic     malformed;
    logic     line_open;
    logic     out_busy;
  } bee_stat_t;

endpackage

// File: src/bee_datapath.sv
module bee_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bee_pkg::bee_cmd_t  cmd_i,
  output bee_pkg::bee_stat_t stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output bee_pkg::bee_out_t  out_data_o
);

  localparam int unsigned AW = bee_pkg::ADDR_W;
  localparam int unsigned DW = bee_pkg::DEPTH_W;

  logic                 val_mem [bee_pkg::STACK_DEPTH];
  bee_pkg::op_code_e    op_mem  [bee_pkg::STACK_DEPTH];

  logic [DW-1:0]          vd_q, vd_d, od_q, od_d;
  logic                   val_top_q, val_top_d, val_sec_q;
  bee_pkg::op_code_e      op_top_q, op_top_d, op_sec_q;
  logic                   malformed_q, malformed_d;
  logic                   line_open_q, line_open_d;
  logic                   pend_q, pend_d;
  logic [bee_pkg::COUNT_W-1:0] count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  bee_pkg::bee_out_t      out_q, out_d;

  logic                   val_we, val_wdata;
  logic [AW-1:0]          val_waddr, val_raddr;
  logic                   op_we;
  logic [AW-1:0]          op_waddr, op_raddr;
  logic                   combined, bad;

  // value stack, top cached in a register, memory holds every entry
  always_comb begin
    val_we    = 1'b0;
    val_waddr = vd_q[AW-1:0];
    val_wdata = pend_q;
    val_top_d = val_top_q;
    vd_d      = vd_q;
    combined  = (op_top_q == bee_pkg::OP_OR) ? (val_top_q | val_sec_q)
                                             : (val_top_q & val_sec_q);
    unique case (cmd_i.val_cmd)
      bee_pkg::VAL_PUSH: begin
        val_we    = 1'b1;
        val_top_d = pend_q;
        vd_d      = vd_q + DW'(1);
      end
      bee_pkg::VAL_COMBINE: begin
        val_we    = 1'b1;
        val_waddr = vd_q[AW-1:0] - AW'(2);
        val_wdata = combined;
        val_top_d = combined;
        vd_d      = vd_q - DW'(1);
      end
      bee_pkg::VAL_FLIP: begin
        val_we    = 1'b1;
        val_waddr = vd_q[AW-1:0] - AW'(1);
        val_wdata = ~val_top_q;
        val_top_d = ~val_top_q;
      end
      default: ;
    endcase
    if (cmd_i.clear_line) begin
      vd_d = '0;
    end
    val_raddr = vd_d[AW-1:0] - AW'(2);
  end

  // operator stack, same scheme
  always_comb begin
    op_we    = 1'b0;
    op_waddr = od_q[AW-1:0];
    op_top_d = op_top_q;
    od_d     = od_q;
    unique case (cmd_i.ops_cmd)
      bee_pkg::OPS_PUSH: begin
        op_we    = 1'b1;
        op_top_d = cmd_i.push_code;
        od_d     = od_q + DW'(1);
      end
      bee_pkg::OPS_POP: begin
        op_top_d = op_sec_q;
        od_d     = od_q - DW'(1);
      end
      default: ;
    endcase
    if (cmd_i.clear_line) begin
      od_d = '0;
    end
    op_raddr = od_d[AW-1:0] - AW'(2);
  end

  always_comb begin
    malformed_d = malformed_q | cmd_i.set_malformed;
    line_open_d = line_open_q | cmd_i.set_line_open;
    if (cmd_i.clear_line) begin
      malformed_d = 1'b0;
      line_open_d = 1'b0;
    end
    pend_d = pend_q;
    if (cmd_i.load_pend) begin
      pend_d = cmd_i.pend_value;
    end else if (cmd_i.flip_pend) begin
      pend_d = ~pend_q;
    end
  end

  // result register
  always_comb begin
    bad         = malformed_q | (vd_q == '0);
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.emit) begin
      if (count_q != bee_pkg::COUNT_MAX) begin
        count_d = count_q + bee_pkg::COUNT_W'(1);
      end
      out_d.truth_value = ~bad & val_top_q;
      out_d.expr_number = count_d;
      out_d.status      = bad;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q        <= '0;
      od_q        <= '0;
      malformed_q <= 1'b0;
      line_open_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vd_q        <= vd_d;
      od_q        <= od_d;
      malformed_q <= malformed_d;
      line_open_q <= line_open_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_top_q <= val_top_d;
    op_top_q  <= op_top_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_sec_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      op_mem[op_waddr] <= cmd_i.push_code;
    end
    op_sec_q <= op_mem[op_raddr];
  end

  always_comb begin
    stat_o.vd_zero   = (vd_q == '0);
    stat_o.vd_lt2    = (vd_q < DW'(2));
    stat_o.vd_full   = (vd_q == DW'(bee_pkg::STACK_DEPTH));
    stat_o.od_zero   = (od_q == '0);
    stat_o.od_full   = (od_q == DW'(bee_pkg::STACK_DEPTH));
    stat_o.op_top    = op_top_q;
    stat_o.malformed = malformed_q;
    stat_o.line_open = line_open_q;
    stat_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/bee_controller.sv
module bee_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bee_pkg::bee_in_t   in_data_i,
  output logic               in_ready_o,
  input  bee_pkg::bee_stat_t stat_i,
  output bee_pkg::bee_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPERAND,
    ST_CLOSE,
    ST_CLOSE_NOT,
    ST_BINARY,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  bee_pkg::op_code_e code_q, code_d;
  logic              accept;
  logic              top_is_not;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign top_is_not = ~stat_i.od_zero & (stat_i.op_top == bee_pkg::OP_NOT);

  always_comb begin
    state_d             = state_q;
    code_d              = code_q;
    cmd_o.val_cmd       = bee_pkg::VAL_NONE;
    cmd_o.ops_cmd       = bee_pkg::OPS_NONE;
    cmd_o.push_code     = code_q;
    cmd_o.set_malformed = 1'b0;
    cmd_o.set_line_open = 1'b0;
    cmd_o.clear_line    = 1'b0;
    cmd_o.load_pend     = 1'b0;
    cmd_o.pend_value    = 1'b0;
    cmd_o.flip_pend     = 1'b0;
    cmd_o.emit          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.end_of_stream) begin
            if (stat_i.line_open) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.clear_line = 1'b1;
            end
          end else if (in_data_i.char_code == bee_pkg::CH_NEWLINE) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.set_line_open = 1'b1;
            if (!stat_i.malformed) begin
              priority case (in_data_i.char_code)
                bee_pkg::CH_TRUE, bee_pkg::CH_FALSE: begin
                  cmd_o.load_pend  = 1'b1;
                  cmd_o.pend_value = (in_data_i.char_code == bee_pkg::CH_TRUE);
                  state_d          = ST_OPERAND;
                end
                bee_pkg::CH_OPEN, bee_pkg::CH_NOT: begin
                  cmd_o.push_code = (in_data_i.char_code == bee_pkg::CH_OPEN) ?
                                    bee_pkg::OP_OPEN : bee_pkg::OP_NOT;
                  if (stat_i.od_full) begin
                    cmd_o.set_malformed = 1'b1;
                  end else begin
                    cmd_o.ops_cmd = bee_pkg::OPS_PUSH;
                  end
                end
                bee_pkg::CH_CLOSE: begin
                  state_d = ST_CLOSE;
                end
                bee_pkg::CH_AND: begin
                  code_d  = bee_pkg::OP_AND;
                  state_d = ST_BINARY;
                end
                bee_pkg::CH_OR: begin
                  code_d  = bee_pkg::OP_OR;
                  state_d = ST_BINARY;
                end
                default: ;
              endcase
            end
          end
        end
      end

      // strip pending nots, then push the operand
      ST_OPERAND: begin
        if (top_is_not) begin
          cmd_o.ops_cmd   = bee_pkg::OPS_POP;
          cmd_o.flip_pend = 1'b1;
        end else begin
          if (stat_i.vd_full) begin
            cmd_o.set_malformed = 1'b1;
          end else begin
            cmd_o.val_cmd = bee_pkg::VAL_PUSH;
          end
          state_d = ST_IDLE;
        end
      end

      ST_CLOSE: begin
        if (stat_i.od_zero || stat_i.op_top == bee_pkg::OP_NOT) begin
          cmd_o.set_malformed = 1'b1;
          state_d             = ST_IDLE;
        end else if (stat_i.op_top == bee_pkg::OP_OPEN) begin
          cmd_o.ops_cmd = bee_pkg::OPS_POP;
          state_d       = ST_CLOSE_NOT;
        end else if (stat_i.vd_lt2) begin
          cmd_o.set_malformed = 1'b1;
          state_d             = ST_IDLE;
        end else begin
          cmd_o.val_cmd = bee_pkg::VAL_COMBINE;
          cmd_o.ops_cmd = bee_pkg::OPS_POP;
        end
      end

      // nots waiting on a finished group
      ST_CLOSE_NOT: begin
        if (top_is_not) begin
          cmd_o.ops_cmd = bee_pkg::OPS_POP;
          if (stat_i.vd_zero) begin
            cmd_o.set_malformed = 1'b1;
            state_d             = ST_IDLE;
          end else begin
            cmd_o.val_cmd = bee_pkg::VAL_FLIP;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_BINARY: begin
        if (!stat_i.od_zero && stat_i.op_top != bee_pkg::OP_OPEN &&
            stat_i.op_top != bee_pkg::OP_NOT && !(stat_i.op_top < code_q)) begin
          if (stat_i.vd_lt2) begin
            cmd_o.set_malformed = 1'b1;
            state_d             = ST_IDLE;
          end else begin
            cmd_o.val_cmd = bee_pkg::VAL_COMBINE;
            cmd_o.ops_cmd = bee_pkg::OPS_POP;
          end
        end else begin
          if (stat_i.od_full) begin
            cmd_o.set_malformed = 1'b1;
          end else begin
            cmd_o.ops_cmd = bee_pkg::OPS_PUSH;
          end
          state_d = ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (stat_i.malformed || stat_i.od_zero) begin
          state_d = ST_EMIT;
        end else if (stat_i.op_top == bee_pkg::OP_OPEN ||
                     stat_i.op_top == bee_pkg::OP_NOT || stat_i.vd_lt2) begin
          cmd_o.set_malformed = 1'b1;
        end else begin
          cmd_o.val_cmd = bee_pkg::VAL_COMBINE;
          cmd_o.ops_cmd = bee_pkg::OPS_POP;
        end
      end

      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit       = 1'b1;
          cmd_o.clear_line = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= bee_pkg::OP_OR;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// File: src/boolean_expression_evaluator.sv
// Evaluates infix Boolean expressions (V, F, !, &, |, parentheses) arriving
// one character per input item, one expression per line.
// Input channel: in_valid_i/in_ready_o with char_code and end_of_stream.
// Output channel: out_valid_o/out_ready_i with truth_value, a saturating
// one-based expr_number and status (1 for a malformed line).
// A newline, or end of stream with a line open, produces one result item.
// V/F first strips each pending ! and then pushes; '&' and '|' combine while
// the top operator has equal or higher precedence, then push; ')' combines
// down to its '(' and then applies its pending !. Each combine or pop is one
// step of the controller over the two stacks, whose second entries come from
// registered reads of the stack memories. A newline combines the remaining
// operators, then its result is written to the output register.
// The output register holds a result until it is taken; the next characters
// are accepted meanwhile, and only a further result waits for it to drain.
// Reset clears the stack depths, the line state, the expression count and
// the output valid; the stack memories are not cleared.
module boolean_expression_evaluator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bee_pkg::bee_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bee_pkg::bee_out_t out_data_o
);

  bee_pkg::bee_cmd_t  cmd;
  bee_pkg::bee_stat_t stat;

  bee_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bee_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/bee_checker.sv
module bee_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input bee_pkg::bee_in_t  in_data_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input bee_pkg::bee_out_t out_data_i
);

  logic plain_char;

  assign plain_char = in_valid_i & in_ready_i & ~in_data_i.end_of_stream &
                      (in_data_i.char_code != bee_pkg::CH_NEWLINE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_bad_is_false: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status |-> !out_data_i.truth_value)
    else $error("malformed result with true value");

  a_number_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.expr_number != '0)
    else $error("zero expression number");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain_char && !out_valid_i |=> !out_valid_i)
    else $error("result from a character that ends no line");

endmodule

bind boolean_expression_evaluator bee_checker u_bee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// File: dv/boolean_expression_evaluator_checker.sv
`timescale 1ns / 1ps

module boolean_expression_evaluator_checker
  import bee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  bee_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  bee_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int MAX_REPORTS = 50;

  bit          truth_stack [STACK_DEPTH];
  op_code_e    op_stack    [STACK_DEPTH];
  int unsigned truth_sp;
  int unsigned op_sp;
  logic [15:0] line_count;
  bit          line_bad;
  bit          line_started;

  bee_out_t    line_results_q[$];
  bee_out_t    want;
  int          mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic clear_line();
    truth_sp     = 0;
    op_sp        = 0;
    line_bad     = 1'b0;
    line_started = 1'b0;
  endtask

  task automatic push_truth(input bit v);
    if (truth_sp >= STACK_DEPTH) begin
      line_bad = 1'b1;
    end else begin
      truth_stack[truth_sp] = v;
      truth_sp++;
    end
  endtask

  task automatic push_op(input op_code_e code);
    if (op_sp >= STACK_DEPTH) begin
      line_bad = 1'b1;
    end else begin
      op_stack[op_sp] = code;
      op_sp++;
    end
  endtask

  // pop two values and push their and/or
  task automatic fold(input op_code_e code);
    bit a;
    bit b;
    if (truth_sp < 2) begin
      line_bad = 1'b1;
    end else begin
      a = truth_stack[truth_sp-1];
      b = truth_stack[truth_sp-2];
      truth_sp--;
      truth_stack[truth_sp-1] = (code == OP_OR) ? (a | b) : (a & b);
    end
  endtask

  task automatic feed_operand(input bit v);
    while (op_sp > 0 && op_stack[op_sp-1] == OP_NOT) begin
      op_sp--;
      v = ~v;
    end
    push_truth(v);
  endtask

  task automatic close_paren();
    bit       done;
    op_code_e t;
    done = 1'b0;
    while (!done && !line_bad) begin
      if (op_sp == 0) begin
        line_bad = 1'b1;
      end else begin
        t = op_stack[op_sp-1];
        if (t == OP_OPEN) begin
          op_sp--;
          done = 1'b1;
        end else if (t == OP_NOT) begin
          line_bad = 1'b1;
        end else begin
          fold(t);
          if (!line_bad) op_sp--;
        end
      end
    end
    while (done && !line_bad && op_sp > 0 && op_stack[op_sp-1] == OP_NOT) begin
      op_sp--;
      if (truth_sp == 0) line_bad = 1'b1;
      else truth_stack[truth_sp-1] = ~truth_stack[truth_sp-1];
    end
  endtask

  task automatic feed_binop(input op_code_e code);
    bit       stop;
    op_code_e t;
    stop = 1'b0;
    while (op_sp > 0 && !stop && !line_bad) begin
      t = op_stack[op_sp-1];
      if (t == OP_OPEN || t == OP_NOT || t < code) begin
        stop = 1'b1;
      end else begin
        fold(t);
        if (!line_bad) op_sp--;
      end
    end
    if (!line_bad) push_op(code);
  endtask

  task automatic finish_line();
    op_code_e t;
    bee_out_t r;
    while (!line_bad && op_sp > 0) begin
      t = op_stack[op_sp-1];
      if (t == OP_OPEN || t == OP_NOT) begin
        line_bad = 1'b1;
      end else begin
        fold(t);
        if (!line_bad) op_sp--;
      end
    end
    if (!line_bad && truth_sp == 0) line_bad = 1'b1;
    if (line_count != COUNT_MAX) line_count++;
    r.truth_value = line_bad ? 1'b0 : truth_stack[truth_sp-1];
    r.expr_number = line_count;
    r.status      = line_bad;
    line_results_q.push_back(r);
    clear_line();
  endtask

  task automatic evaluate_char(input bee_in_t item);
    if (item.end_of_stream) begin
      if (line_started) finish_line();
      else clear_line();
    end else if (item.char_code == CH_NEWLINE) begin
      finish_line();
    end else begin
      line_started = 1'b1;
      if (!line_bad) begin
        case (item.char_code)
          CH_TRUE:  feed_operand(1'b1);
          CH_FALSE: feed_operand(1'b0);
          CH_OPEN:  push_op(OP_OPEN);
          CH_CLOSE: close_paren();
          CH_NOT:   push_op(OP_NOT);
          CH_AND:   feed_binop(OP_AND);
          CH_OR:    feed_binop(OP_OR);
          default:  ;
        endcase
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      line_count = '0;
      line_results_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) evaluate_char(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (line_results_q.size() == 0) begin
          report("result with none pending", out_data_i.expr_number, 0);
        end else begin
          want = line_results_q.pop_front();
          if (out_data_i.truth_value !== want.truth_value)
            report("truth_value", out_data_i.truth_value, want.truth_value);
          if (out_data_i.expr_number !== want.expr_number)
            report("expr_number", out_data_i.expr_number, want.expr_number);
          if (out_data_i.status !== want.status)
            report("status", out_data_i.status, want.status);
        end
      end
      pending_o <= line_results_q.size();
    end
  end

endmodule

// File: dv/boolean_expression_evaluator_tb.sv
`timescale 1ns / 1ps

module boolean_expression_evaluator_tb;
  import bee_pkg::*;

  localparam logic [7:0] CH_SPACE        = 8'h20;
  localparam int         WATCHDOG_LIMIT  = 3000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 200;
  localparam int         PHASE_ITEMS     = 585;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bee_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bee_out_t out_data;

  int       fail_count;
  int       pending;
  int       in_idle_pct  = 0;
  int       out_idle_pct = 0;
  bit       hold_off_req = 1'b0;
  int       quiet_cycles = 0;
  bee_in_t  line_q[$];

  boolean_expression_evaluator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  boolean_expression_evaluator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result receiver
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic put(input logic [7:0] c);
    line_q.push_back(bee_in_t'{char_code: c, end_of_stream: 1'b0});
  endtask

  task automatic put_gap();
    if ($urandom_range(9) == 0) put(CH_SPACE);
  endtask

  task automatic put_str(input string s);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_end();
    if ($urandom_range(19) == 0)
      line_q.push_back(bee_in_t'{char_code: 8'($urandom_range(255)), end_of_stream: 1'b1});
    else
      put(CH_NEWLINE);
  endtask

  function automatic logic [7:0] pick_sym();
    case ($urandom_range(8))
      0:       return CH_TRUE;
      1:       return CH_FALSE;
      2:       return CH_OPEN;
      3:       return CH_CLOSE;
      4:       return CH_NOT;
      5:       return CH_AND;
      6:       return CH_OR;
      7:       return CH_SPACE;
      default: return CH_NEWLINE;
    endcase
  endfunction

  function automatic logic [7:0] pick_operand();
    return $urandom_range(1) ? CH_TRUE : CH_FALSE;
  endfunction

  task automatic gen_expr(input int lvl);
    int pick;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0) begin
      put(CH_NOT);
      put_gap();
    end
    pick = (lvl == 0) ? 0 : $urandom_range(2);
    case (pick)
      0: put(pick_operand());
      1: begin
        put(CH_OPEN);
        put_gap();
        gen_expr(lvl - 1);
        put(CH_CLOSE);
      end
      default: begin
        gen_expr(lvl - 1);
        put_gap();
        put($urandom_range(1) ? CH_AND : CH_OR);
        put_gap();
        gen_expr(lvl - 1);
      end
    endcase
    put_gap();
  endtask

  task automatic build_line();
    int kind;
    int idx;
    int k;
    kind = $urandom_range(99);
    if (kind < 60) begin
      gen_expr($urandom_range(4));
    end else if (kind < 70) begin
      gen_expr($urandom_range(1, 4));
      idx = $urandom_range(line_q.size() - 1);
      case ($urandom_range(2))
        0:       line_q.delete(idx);
        1:       line_q.insert(idx, bee_in_t'{char_code: pick_sym(), end_of_stream: 1'b0});
        default: line_q[idx].char_code = pick_sym();
      endcase
    end else if (kind < 82) begin
      repeat ($urandom_range(12)) put($urandom_range(1) ? pick_sym() : 8'($urandom_range(255)));
    end else if (kind < 90) begin
      k = $urandom_range(60, 68);
      case ($urandom_range(2))
        0: begin
          repeat (k) put(CH_OPEN);
          put(pick_operand());
          repeat (k) put(CH_CLOSE);
        end
        1: begin
          repeat (k) put(CH_NOT);
          put(pick_operand());
        end
        default: begin
          repeat (k) begin
            put(pick_operand());
            put_gap();
          end
        end
      endcase
    end else if (kind < 94) begin
      if ($urandom_range(1)) gen_expr(2);
    end else begin
      case ($urandom_range(6))
        0:       put_str("()");
        1:       put_str("!");
        2:       put_str("(V");
        3:       put_str("V&");
        4:       put_str("&V");
        5:       put_str("V!)");
        default: put_str("F)");
      endcase
    end
    put_end();
  endtask

  task automatic send_item(input bee_in_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i]);
    line_q.delete();
  endtask

  task automatic random_phase(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      build_line();
      sent += line_q.size();
      send_line();
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    in_idle_pct  = 26;
    out_idle_pct = 51;
    put_str("\nV\n!F x\nV|F&F\n(V!)\n)V\nVF");
    line_q.push_back(bee_in_t'{char_code: 8'hff, end_of_stream: 1'b1});
    line_q.push_back(bee_in_t'{char_code: 8'h00, end_of_stream: 1'b1});
    send_line();

    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);
    in_idle_pct  = 51;
    out_idle_pct = 26;
    random_phase(PHASE_ITEMS);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: boolean_expression_evaluator.f
src/bee_pkg.sv
src/bee_datapath.sv
src/bee_controller.sv
src/boolean_expression_evaluator.sv
src/bee_checker.sv
dv/boolean_expression_evaluator_checker.sv
dv/boolean_expression_evaluator_tb.sv
